// File: rtl/lc2k_five_stage_pipeline_unit_assert.svh
// Assertion macros for the LC-2K pipeline unit.
// Included by the top level; depends on nothing else.
`ifndef LC2K_FIVE_STAGE_PIPELINE_UNIT_ASSERT_SVH
`define LC2K_FIVE_STAGE_PIPELINE_UNIT_ASSERT_SVH

// same-cycle implication
`define LC2K_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LC2K_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lc2k_pkg.sv
// Shared types, constants and decode helpers for the LC-2K pipeline unit.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package lc2k_pkg;

  localparam int unsigned MEM_DEPTH = 65536;
  localparam int unsigned MEM_AW    = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned RF_AW     = 3;

  localparam logic [WORD_W-1:0] NOOP_WORD = 32'h01C0_0000;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } lc2k_op_e;

  typedef struct packed {
    logic                     req_type;
    logic [15:0]              load_addr;
    logic signed [WORD_W-1:0] load_word;
  } lc2k_in_t;

  typedef struct packed {
    logic                     halted;
    logic [15:0]              pc_value;
    logic [31:0]              cycle_count;
    logic                     wb_valid;
    logic [2:0]               wb_reg;
    logic signed [WORD_W-1:0] wb_data;
  } lc2k_out_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } lc2k_mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [RF_AW-1:0]  idx;
    logic [WORD_W-1:0] data;
  } lc2k_rf_wr_t;

  typedef struct packed {
    logic [MEM_AW-1:0] imem_addr;
    logic [MEM_AW-1:0] dmem_addr;
    logic [RF_AW-1:0]  rf_ra;
    logic [RF_AW-1:0]  rf_rb;
  } lc2k_rd_t;

  function automatic lc2k_op_e op_of(input logic [WORD_W-1:0] w);
    return lc2k_op_e'(w[24:22]);
  endfunction

  function automatic logic [RF_AW-1:0] ra_of(input logic [WORD_W-1:0] w);
    return w[21:19];
  endfunction

  function automatic logic [RF_AW-1:0] rb_of(input logic [WORD_W-1:0] w);
    return w[18:16];
  endfunction

  function automatic logic writes_reg(input logic [WORD_W-1:0] w);
    return (op_of(w) == OP_ADD) || (op_of(w) == OP_NOR) || (op_of(w) == OP_LW);
  endfunction

  function automatic logic [RF_AW-1:0] dest_of(input logic [WORD_W-1:0] w);
    return (op_of(w) == OP_LW) ? w[18:16] : w[2:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/lc2k_mem.sv
// Single-port-write, single-port-read word memory with registered read and
// write-through on a same-address write. Depends on lc2k_pkg.
`default_nettype none

module lc2k_mem (
  input  logic                         clk_i,
  input  lc2k_pkg::lc2k_mem_wr_t       wr_i,
  input  logic [lc2k_pkg::MEM_AW-1:0]  rd_addr_i,
  output logic [lc2k_pkg::WORD_W-1:0]  rd_data_o
);
  import lc2k_pkg::*;

  logic [WORD_W-1:0] mem_q [MEM_DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/lc2k_regfile.sv
// Eight-entry register file, cleared at reset, two registered read ports
// with write-through. Depends on lc2k_pkg.
`default_nettype none

module lc2k_regfile (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lc2k_pkg::lc2k_rf_wr_t        wr_i,
  input  logic [lc2k_pkg::RF_AW-1:0]   ra_i,
  input  logic [lc2k_pkg::RF_AW-1:0]   rb_i,
  output logic [lc2k_pkg::WORD_W-1:0]  rd_a_o,
  output logic [lc2k_pkg::WORD_W-1:0]  rd_b_o
);
  import lc2k_pkg::*;

  logic [WORD_W-1:0] rf_q [REG_COUNT];
  logic [WORD_W-1:0] rd_a_q;
  logic [WORD_W-1:0] rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= '0;
      end
      rd_a_q <= '0;
      rd_b_q <= '0;
    end else begin
      if (wr_i.en) begin
        rf_q[wr_i.idx] <= wr_i.data;
      end
      rd_a_q <= (wr_i.en && (wr_i.idx == ra_i)) ? wr_i.data : rf_q[ra_i];
      rd_b_q <= (wr_i.en && (wr_i.idx == rb_i)) ? wr_i.data : rf_q[rb_i];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

// File: rtl/lc2k_core.sv
// Pipeline state registers and the per-beat next-state logic (IF..WB,
// hazard stall, forwarding, branch squash). Depends on lc2k_pkg.
`default_nettype none

module lc2k_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  lc2k_pkg::lc2k_in_t           item_i,
  input  logic [lc2k_pkg::WORD_W-1:0]  imem_rd_i,
  input  logic [lc2k_pkg::WORD_W-1:0]  dmem_rd_i,
  input  logic [lc2k_pkg::WORD_W-1:0]  rf_a_i,
  input  logic [lc2k_pkg::WORD_W-1:0]  rf_b_i,
  output lc2k_pkg::lc2k_rd_t           rd_o,
  output lc2k_pkg::lc2k_mem_wr_t       sw_wr_o,
  output lc2k_pkg::lc2k_rf_wr_t        rf_wr_o,
  output lc2k_pkg::lc2k_out_t          res_o
);
  import lc2k_pkg::*;

  logic [MEM_AW-1:0] fetch_pc_q, fetch_pc_d;
  logic [WORD_W-1:0] ifid_instr_q, ifid_instr_d;
  logic [MEM_AW-1:0] ifid_npc_q, ifid_npc_d;
  logic [WORD_W-1:0] idex_instr_q, idex_instr_d;
  logic [MEM_AW-1:0] idex_npc_q, idex_npc_d;
  logic [WORD_W-1:0] idex_a_q, idex_a_d;
  logic [WORD_W-1:0] idex_b_q, idex_b_d;
  logic [15:0]       idex_off_q, idex_off_d;
  logic [WORD_W-1:0] exmem_instr_q, exmem_instr_d;
  logic [MEM_AW-1:0] exmem_tgt_q, exmem_tgt_d;
  logic              exmem_eq_q, exmem_eq_d;
  logic [WORD_W-1:0] exmem_alu_q, exmem_alu_d;
  logic [WORD_W-1:0] exmem_b_q, exmem_b_d;
  logic [WORD_W-1:0] memwb_instr_q, memwb_instr_d;
  logic [WORD_W-1:0] memwb_data_q, memwb_data_d;
  logic [WORD_W-1:0] wbend_instr_q, wbend_instr_d;
  logic [WORD_W-1:0] wbend_data_q, wbend_data_d;
  logic [31:0]       cycles_q, cycles_d;

  logic              tick;
  logic              stall;
  logic              taken;
  logic              sw_en;
  logic              wb_en;
  logic [RF_AW-1:0]  wb_idx;
  logic [WORD_W-1:0] fa, fb;
  logic [WORD_W-1:0] off32;
  logic [WORD_W-1:0] n_ext;
  lc2k_op_e          eop, mop;

  always_comb begin
    tick  = acc_i && (item_i.req_type == REQ_TICK) && (op_of(memwb_instr_q) != OP_HALT);
    eop   = op_of(idex_instr_q);
    mop   = op_of(exmem_instr_q);
    stall = (eop == OP_LW) && ((ra_of(ifid_instr_q) == rb_of(idex_instr_q)) ||
                               (rb_of(ifid_instr_q) == rb_of(idex_instr_q)));

    // operand forwarding, youngest stage last so it wins
    fa = idex_a_q;
    fb = idex_b_q;
    if (writes_reg(wbend_instr_q)) begin
      if (ra_of(idex_instr_q) == dest_of(wbend_instr_q)) fa = wbend_data_q;
      if (rb_of(idex_instr_q) == dest_of(wbend_instr_q)) fb = wbend_data_q;
    end
    if (writes_reg(memwb_instr_q)) begin
      if (ra_of(idex_instr_q) == dest_of(memwb_instr_q)) fa = memwb_data_q;
      if (rb_of(idex_instr_q) == dest_of(memwb_instr_q)) fb = memwb_data_q;
    end
    if (writes_reg(exmem_instr_q)) begin
      if (ra_of(idex_instr_q) == dest_of(exmem_instr_q)) fa = exmem_alu_q;
      if (rb_of(idex_instr_q) == dest_of(exmem_instr_q)) fb = exmem_alu_q;
    end

    off32 = {{16{idex_off_q[15]}}, idex_off_q};
    n_ext = {16'b0, idex_npc_q} + off32;

    // IF / ID
    fetch_pc_d   = fetch_pc_q + MEM_AW'(1);
    ifid_instr_d = imem_rd_i;
    ifid_npc_d   = fetch_pc_q + MEM_AW'(1);
    idex_instr_d = ifid_instr_q;
    idex_npc_d   = ifid_npc_q;
    idex_a_d     = idex_a_q;
    idex_b_d     = idex_b_q;
    idex_off_d   = idex_off_q;
    if (stall) begin
      idex_instr_d = NOOP_WORD;
      fetch_pc_d   = fetch_pc_q;
      ifid_instr_d = ifid_instr_q;
      ifid_npc_d   = ifid_npc_q;
    end else begin
      idex_a_d   = rf_a_i;
      idex_b_d   = rf_b_i;
      idex_off_d = ifid_instr_q[15:0];
    end

    // EX
    exmem_instr_d = idex_instr_q;
    exmem_tgt_d   = n_ext[MEM_AW-1:0];
    exmem_eq_d    = exmem_eq_q;
    exmem_alu_d   = exmem_alu_q;
    exmem_b_d     = exmem_b_q;
    case (eop)
      OP_ADD:  exmem_alu_d = fa + fb;
      OP_NOR:  exmem_alu_d = ~(fa | fb);
      OP_LW,
      OP_SW:   exmem_alu_d = fa + off32;
      OP_BEQ: begin
        exmem_eq_d  = (fa == fb);
        exmem_alu_d = n_ext;
      end
      OP_NOOP: exmem_alu_d = '0;
      default: ;
    endcase
    if (eop != OP_NOOP) exmem_b_d = fb;

    // MEM
    memwb_instr_d = exmem_instr_q;
    memwb_data_d  = memwb_data_q;
    taken         = 1'b0;
    sw_en         = 1'b0;
    case (mop)
      OP_LW:   memwb_data_d = dmem_rd_i;
      OP_SW:   sw_en = 1'b1;
      OP_BEQ:  taken = exmem_eq_q;
      OP_NOOP,
      OP_HALT: memwb_data_d = '0;
      default: memwb_data_d = exmem_alu_q;
    endcase
    if (taken) begin
      fetch_pc_d    = exmem_tgt_q;
      ifid_instr_d  = NOOP_WORD;
      idex_instr_d  = NOOP_WORD;
      exmem_instr_d = NOOP_WORD;
    end

    // WB
    wb_en         = writes_reg(memwb_instr_q);
    wb_idx        = dest_of(memwb_instr_q);
    wbend_instr_d = memwb_instr_q;
    wbend_data_d  = memwb_data_q;
    cycles_d      = cycles_q + 32'd1;

    if (!tick) begin
      fetch_pc_d    = fetch_pc_q;
      ifid_instr_d  = ifid_instr_q;
      ifid_npc_d    = ifid_npc_q;
      idex_instr_d  = idex_instr_q;
      idex_npc_d    = idex_npc_q;
      idex_a_d      = idex_a_q;
      idex_b_d      = idex_b_q;
      idex_off_d    = idex_off_q;
      exmem_instr_d = exmem_instr_q;
      exmem_tgt_d   = exmem_tgt_q;
      exmem_eq_d    = exmem_eq_q;
      exmem_alu_d   = exmem_alu_q;
      exmem_b_d     = exmem_b_q;
      memwb_instr_d = memwb_instr_q;
      memwb_data_d  = memwb_data_q;
      wbend_instr_d = wbend_instr_q;
      wbend_data_d  = wbend_data_q;
      cycles_d      = cycles_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_pc_q    <= '0;
      ifid_instr_q  <= NOOP_WORD;
      ifid_npc_q    <= '0;
      idex_instr_q  <= NOOP_WORD;
      idex_npc_q    <= '0;
      idex_a_q      <= '0;
      idex_b_q      <= '0;
      idex_off_q    <= '0;
      exmem_instr_q <= NOOP_WORD;
      exmem_tgt_q   <= '0;
      exmem_eq_q    <= 1'b0;
      exmem_alu_q   <= '0;
      exmem_b_q     <= '0;
      memwb_instr_q <= NOOP_WORD;
      memwb_data_q  <= '0;
      wbend_instr_q <= NOOP_WORD;
      wbend_data_q  <= '0;
      cycles_q      <= '0;
    end else begin
      fetch_pc_q    <= fetch_pc_d;
      ifid_instr_q  <= ifid_instr_d;
      ifid_npc_q    <= ifid_npc_d;
      idex_instr_q  <= idex_instr_d;
      idex_npc_q    <= idex_npc_d;
      idex_a_q      <= idex_a_d;
      idex_b_q      <= idex_b_d;
      idex_off_q    <= idex_off_d;
      exmem_instr_q <= exmem_instr_d;
      exmem_tgt_q   <= exmem_tgt_d;
      exmem_eq_q    <= exmem_eq_d;
      exmem_alu_q   <= exmem_alu_d;
      exmem_b_q     <= exmem_b_d;
      memwb_instr_q <= memwb_instr_d;
      memwb_data_q  <= memwb_data_d;
      wbend_instr_q <= wbend_instr_d;
      wbend_data_q  <= wbend_data_d;
      cycles_q      <= cycles_d;
    end
  end

  // read addresses track next state so read data is ready for the next beat
  assign rd_o.imem_addr = fetch_pc_d;
  assign rd_o.dmem_addr = exmem_alu_d[MEM_AW-1:0];
  assign rd_o.rf_ra     = ra_of(ifid_instr_d);
  assign rd_o.rf_rb     = rb_of(ifid_instr_d);

  assign sw_wr_o.en   = tick && sw_en;
  assign sw_wr_o.addr = exmem_alu_q[MEM_AW-1:0];
  assign sw_wr_o.data = exmem_b_q;

  assign rf_wr_o.en   = tick && wb_en;
  assign rf_wr_o.idx  = wb_idx;
  assign rf_wr_o.data = memwb_data_q;

  assign res_o.halted      = (op_of(memwb_instr_d) == OP_HALT);
  assign res_o.pc_value    = fetch_pc_d;
  assign res_o.cycle_count = cycles_d;
  assign res_o.wb_valid    = tick && wb_en;
  assign res_o.wb_reg      = (tick && wb_en) ? wb_idx : '0;
  assign res_o.wb_data     = (tick && wb_en) ? memwb_data_q : '0;

endmodule

`default_nettype wire

// File: rtl/lc2k_five_stage_pipeline_unit.sv
// LC-2K five-stage pipeline unit: one beat in gives one beat out, either a
// memory load or one pipeline cycle. After reset in_stall_o stays high while
// both memories are swept to zero. After that one beat is taken per clock
// whenever the result register is empty or being drained; each tick is one
// pipeline cycle, with the instruction, data and register file reads issued
// from the next-state addresses, so the critical path is forwarding, one
// 32-bit add and the next-pc select. Depends on lc2k_pkg, lc2k_mem,
// lc2k_regfile, lc2k_core and the assertion header.
`default_nettype none

`include "lc2k_five_stage_pipeline_unit_assert.svh"

module lc2k_five_stage_pipeline_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lc2k_pkg::lc2k_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lc2k_pkg::lc2k_out_t  out_data_o
);
  import lc2k_pkg::*;

  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_idx_q;
  logic              out_valid_q, out_valid_d;
  lc2k_out_t         out_q;
  logic              acc;

  lc2k_out_t         res;
  lc2k_rd_t          rd;
  lc2k_mem_wr_t      sw_wr, load_wr, clr_wr, imem_wr, dmem_wr;
  lc2k_rf_wr_t       rf_wr;
  logic [WORD_W-1:0] imem_rd, dmem_rd, rf_a, rf_b;

  assign in_stall_o = clr_busy_q || (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;

  assign load_wr.en   = acc && (in_data_i.req_type == REQ_LOAD);
  assign load_wr.addr = in_data_i.load_addr[MEM_AW-1:0];
  assign load_wr.data = in_data_i.load_word;

  assign clr_wr.en   = 1'b1;
  assign clr_wr.addr = clr_idx_q;
  assign clr_wr.data = '0;

  assign imem_wr = clr_busy_q ? clr_wr : load_wr;
  assign dmem_wr = clr_busy_q ? clr_wr : (load_wr.en ? load_wr : sw_wr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + MEM_AW'(1);
      if (&clr_idx_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  lc2k_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .item_i    (in_data_i),
    .imem_rd_i (imem_rd),
    .dmem_rd_i (dmem_rd),
    .rf_a_i    (rf_a),
    .rf_b_i    (rf_b),
    .rd_o      (rd),
    .sw_wr_o   (sw_wr),
    .rf_wr_o   (rf_wr),
    .res_o     (res)
  );

  lc2k_mem u_imem (
    .clk_i     (clk_i),
    .wr_i      (imem_wr),
    .rd_addr_i (rd.imem_addr),
    .rd_data_o (imem_rd)
  );

  lc2k_mem u_dmem (
    .clk_i     (clk_i),
    .wr_i      (dmem_wr),
    .rd_addr_i (rd.dmem_addr),
    .rd_data_o (dmem_rd)
  );

  lc2k_regfile u_rf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (rf_wr),
    .ra_i   (rd.rf_ra),
    .rb_i   (rd.rf_rb),
    .rd_a_o (rf_a),
    .rd_b_o (rf_b)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (acc) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LC2K_ASSERT_NOW(a_no_result_in_sweep, clk_i, rst_ni, clr_busy_q, !out_valid_q, "result during memory sweep")
  `LC2K_ASSERT_NEXT(a_load_no_wb, clk_i, rst_ni, acc && (in_data_i.req_type == REQ_LOAD), out_valid_q && !out_q.wb_valid, "load beat reported a register write")
  `LC2K_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, out_valid_q && out_q.halted, out_q.halted, "halted dropped")

endmodule

`default_nettype wire

// File: bench/lc2k_pipeline_checker.sv
// Checker for the LC-2K pipeline unit: watches both channels, keeps its own
// copy of the pipeline state and compares every output beat with the prediction.
// Depends on lc2k_pkg.
module lc2k_pipeline_checker
  import lc2k_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  lc2k_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  lc2k_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  bit   [31:0] imem_m [MEM_DEPTH];
  bit   [31:0] dmem_m [MEM_DEPTH];
  bit   [31:0] regs_m [REG_COUNT];
  logic [15:0] pc_r;
  logic [31:0] ifid_ins;
  logic [15:0] ifid_npc;
  logic [31:0] idex_ins;
  logic [15:0] idex_npc;
  logic [31:0] idex_a, idex_b, idex_off;
  logic [31:0] exmem_ins, exmem_tgt, exmem_alu, exmem_b;
  logic        exmem_eq;
  logic [31:0] memwb_ins, memwb_data;
  logic [31:0] wbend_ins, wbend_data;
  logic [31:0] cycles_r;

  lc2k_out_t   pipe_results_q [$];

  function automatic lc2k_op_e opcode(input logic [31:0] w);
    return lc2k_op_e'(w[24:22]);
  endfunction

  function automatic bit is_writer(input logic [31:0] w);
    return opcode(w) inside {OP_ADD, OP_NOR, OP_LW};
  endfunction

  function automatic logic [2:0] dest_reg(input logic [31:0] w);
    return (opcode(w) == OP_LW) ? w[18:16] : w[2:0];
  endfunction

  function automatic void bypass(input logic [31:0] src, input logic [31:0] data,
                                 input logic [31:0] consumer,
                                 inout logic [31:0] a, inout logic [31:0] b);
    if (!is_writer(src)) return;
    if (consumer[21:19] == dest_reg(src)) a = data;
    if (consumer[18:16] == dest_reg(src)) b = data;
  endfunction

  function automatic lc2k_out_t run_pipe_beat(input lc2k_in_t beat);
    lc2k_out_t   r;
    logic [31:0] n_ifi, n_idi, n_exi, n_mwi;
    logic [15:0] n_ifpc, n_idpc, n_pc;
    logic [31:0] a, bv, n_a, n_b, n_off, n_ext, n_exalu, n_exb, n_mwd;
    logic        n_exeq;
    lc2k_op_e    eop, mop, wop;
    logic        wv;
    logic [2:0]  wr;
    logic [31:0] wd;
    wv = 1'b0;
    wr = '0;
    wd = '0;
    if (beat.req_type == REQ_LOAD) begin
      imem_m[beat.load_addr] = beat.load_word;
      dmem_m[beat.load_addr] = beat.load_word;
    end else if (opcode(memwb_ins) != OP_HALT) begin
      n_ifi   = imem_m[pc_r];
      n_ifpc  = pc_r + 16'd1;
      n_pc    = n_ifpc;
      n_idi   = ifid_ins;
      n_idpc  = ifid_npc;
      n_a     = idex_a;
      n_b     = idex_b;
      n_off   = idex_off;
      a       = idex_a;
      bv      = idex_b;
      eop     = opcode(idex_ins);
      n_exi   = idex_ins;
      n_ext   = {16'd0, idex_npc} + idex_off;
      n_exeq  = exmem_eq;
      n_exalu = exmem_alu;
      n_exb   = exmem_b;
      mop     = opcode(exmem_ins);
      n_mwi   = exmem_ins;
      n_mwd   = memwb_data;
      wop     = opcode(memwb_ins);
      cycles_r = cycles_r + 32'd1;

      // load-use: both source fields compared, whatever the opcode
      if (eop == OP_LW && (ifid_ins[21:19] == idex_ins[18:16] ||
                           ifid_ins[18:16] == idex_ins[18:16])) begin
        n_idi  = NOOP_WORD;
        n_pc   = pc_r;
        n_ifi  = ifid_ins;
        n_ifpc = ifid_npc;
      end else begin
        n_a   = regs_m[ifid_ins[21:19]];
        n_b   = regs_m[ifid_ins[18:16]];
        n_off = {{16{ifid_ins[15]}}, ifid_ins[15:0]};
      end

      // youngest stage applied last
      bypass(wbend_ins, wbend_data, idex_ins, a, bv);
      bypass(memwb_ins, memwb_data, idex_ins, a, bv);
      bypass(exmem_ins, exmem_alu, idex_ins, a, bv);

      case (eop)
        OP_ADD:       n_exalu = a + bv;
        OP_NOR:       n_exalu = ~(a | bv);
        OP_LW, OP_SW: n_exalu = a + idex_off;
        OP_BEQ: begin
          n_exeq  = (a == bv);
          n_exalu = n_ext;
        end
        default: ;
      endcase
      if (eop == OP_NOOP) n_exalu = '0;
      else n_exb = bv;

      case (mop)
        OP_LW: n_mwd = dmem_m[exmem_alu[15:0]];
        OP_SW: dmem_m[exmem_alu[15:0]] = exmem_b;
        OP_BEQ: begin
          if (exmem_eq) begin
            n_pc  = exmem_tgt[15:0];
            n_ifi = NOOP_WORD;
            n_idi = NOOP_WORD;
            n_exi = NOOP_WORD;
          end
        end
        OP_NOOP, OP_HALT: n_mwd = '0;
        default: n_mwd = exmem_alu;
      endcase

      if (wop == OP_LW) begin
        wv = 1'b1;
        wr = memwb_ins[18:16];
      end else if (wop == OP_ADD || wop == OP_NOR) begin
        wv = 1'b1;
        wr = memwb_ins[2:0];
      end
      if (wv) begin
        wd = memwb_data;
        regs_m[wr] = wd;
      end

      wbend_ins  = memwb_ins;
      wbend_data = memwb_data;
      memwb_ins  = n_mwi;
      memwb_data = n_mwd;
      exmem_ins  = n_exi;
      exmem_tgt  = n_ext;
      exmem_eq   = n_exeq;
      exmem_alu  = n_exalu;
      exmem_b    = n_exb;
      idex_ins   = n_idi;
      idex_npc   = n_idpc;
      idex_a     = n_a;
      idex_b     = n_b;
      idex_off   = n_off;
      ifid_ins   = n_ifi;
      ifid_npc   = n_ifpc;
      pc_r       = n_pc;
    end
    r.halted      = (opcode(memwb_ins) == OP_HALT);
    r.pc_value    = pc_r;
    r.cycle_count = cycles_r;
    r.wb_valid    = wv;
    r.wb_reg      = wr;
    r.wb_data     = wd;
    return r;
  endfunction

  function automatic string show(input lc2k_out_t r);
    return $sformatf("halted=%0d pc=%h cycles=%0d wb=%0d r%0d data=%h",
                     r.halted, r.pc_value, r.cycle_count, r.wb_valid, r.wb_reg,
                     r.wb_data);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lc2k_out_t want;
    if (!rst_ni) begin
      foreach (imem_m[i]) begin
        imem_m[i] = '0;
        dmem_m[i] = '0;
      end
      foreach (regs_m[i]) regs_m[i] = '0;
      pc_r       = '0;
      ifid_ins   = NOOP_WORD;
      ifid_npc   = '0;
      idex_ins   = NOOP_WORD;
      idex_npc   = '0;
      idex_a     = '0;
      idex_b     = '0;
      idex_off   = '0;
      exmem_ins  = NOOP_WORD;
      exmem_tgt  = '0;
      exmem_eq   = 1'b0;
      exmem_alu  = '0;
      exmem_b    = '0;
      memwb_ins  = NOOP_WORD;
      memwb_data = '0;
      wbend_ins  = NOOP_WORD;
      wbend_data = '0;
      cycles_r   = '0;
      pipe_results_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) pipe_results_q.push_back(run_pipe_beat(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (pipe_results_q.size() == 0) begin
          note_failure({"result beat with nothing expected: ", show(out_data_i)});
        end else begin
          want = pipe_results_q.pop_front();
          if (out_data_i.halted !== want.halted ||
              out_data_i.pc_value !== want.pc_value ||
              out_data_i.cycle_count !== want.cycle_count ||
              out_data_i.wb_valid !== want.wb_valid ||
              out_data_i.wb_reg !== want.wb_reg ||
              out_data_i.wb_data !== want.wb_data)
            note_failure({"mismatch: expected ", show(want), " got ", show(out_data_i)});
        end
      end
    end
    pending_o = pipe_results_q.size();
  end

endmodule

// File: bench/tb_top.sv
// Testbench top for the LC-2K pipeline unit: clock, reset, program stimulus
// with random idling on both channels, and the verdict.
// Depends on lc2k_pkg, lc2k_five_stage_pipeline_unit and lc2k_pipeline_checker.
module tb_top;
  import lc2k_pkg::*;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  lc2k_in_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  lc2k_out_t out_data_o;

  int          fail_count;
  int          pending;
  logic [15:0] last_pc    = '0;
  logic        last_halt  = 1'b0;
  bit          calm       = 1'b0;
  int          stall_left = 0;
  int          n_loads    = 0;
  int          n_ticks    = 0;

  always #5 clk_i = ~clk_i;

  lc2k_five_stage_pipeline_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  lc2k_pipeline_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      last_pc   <= out_data_o.pc_value;
      last_halt <= out_data_o.halted;
    end
  end

  // result-side back-pressure in bursts
  always @(negedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 8);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [31:0] insn(input lc2k_op_e op, input logic [2:0] ra,
                                       input logic [2:0] rb, input logic [15:0] low);
    return {7'd0, op, ra, rb, low};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_insn();
    logic [31:0] w;
    int          pick;
    w    = $urandom;
    pick = $urandom_range(0, 19);
    if (pick < 4) begin
      w[24:22] = OP_ADD;
    end else if (pick < 7) begin
      w[24:22] = OP_NOR;
    end else if (pick < 14) begin
      w[24:22] = (pick < 11) ? OP_LW : OP_SW;
      if ($urandom_range(0, 1) == 1) begin
        w[21:19] = 3'd0;
        w[15:0]  = 16'($urandom_range(0, 31));
      end
    end else if (pick < 17) begin
      w[24:22] = OP_BEQ;
      if ($urandom_range(0, 3) != 0) w[15:0] = 16'($urandom_range(0, 6)) - 16'd2;
    end else if (pick == 17) begin
      w[24:22] = OP_NOOP;
    end else if (pick == 18) begin
      w[24:22] = OP_JALR;
    end else if (w[24:22] == OP_HALT) begin
      w[24:22] = OP_NOOP;
    end
    return w;
  endfunction

  function automatic lc2k_in_t load_beat(input logic [15:0] addr, input logic [31:0] word);
    lc2k_in_t b;
    b.req_type  = REQ_LOAD;
    b.load_addr = addr;
    b.load_word = word;
    return b;
  endfunction

  function automatic lc2k_in_t tick_beat();
    lc2k_in_t b;
    b.req_type  = REQ_TICK;
    b.load_addr = 16'($urandom);
    b.load_word = $urandom;
    return b;
  endfunction

  // entered and left at a falling edge; valid stays high for a following beat
  task automatic send_beat(input lc2k_in_t beat);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    if (beat.req_type == REQ_LOAD) n_loads++;
    else n_ticks++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    logic [15:0] base;
    int          k;
    bit          flushed;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extreme words and addresses, every opcode but halt, load-use stall,
    // negative offset wrapping the data address, taken branch squash
    send_beat(load_beat(16'hFFFF, 32'h7FFF_FFFF));
    send_beat(load_beat(16'd20, 32'h7FFF_FFFF));
    send_beat(load_beat(16'd21, 32'h8000_0000));
    send_beat(load_beat(16'd0, insn(OP_LW, 3'd0, 3'd1, 16'd20)));
    send_beat(load_beat(16'd1, insn(OP_ADD, 3'd1, 3'd1, 16'd2)));
    send_beat(load_beat(16'd2, insn(OP_NOR, 3'd2, 3'd1, 16'd3)));
    send_beat(load_beat(16'd3, insn(OP_SW, 3'd0, 3'd3, 16'd22)));
    send_beat(load_beat(16'd4, insn(OP_LW, 3'd0, 3'd4, 16'd22)));
    send_beat(load_beat(16'd5, insn(OP_LW, 3'd0, 3'd5, 16'hFFFF)));
    send_beat(load_beat(16'd6, insn(OP_BEQ, 3'd1, 3'd5, 16'd1)));
    send_beat(load_beat(16'd7, insn(OP_ADD, 3'd1, 3'd1, 16'd6)));
    send_beat(load_beat(16'd8, insn(OP_JALR, 3'd5, 3'd6, 16'd0)));
    send_beat(load_beat(16'd9, NOOP_WORD));
    repeat (12) send_beat(tick_beat());

    // random programs written at the fetch address, with noise between
    while (n_loads + n_ticks < 1330) begin
      if (n_loads + n_ticks > 1120) calm = 1'b1;
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(3, 10)) begin
          if ($urandom_range(0, 1) == 1) send_beat(load_beat(16'($urandom), $urandom));
          else send_beat(tick_beat());
        end
      end else begin
        drain();
        base = last_pc;
        repeat ($urandom_range(0, 3))
          send_beat(load_beat(16'($urandom_range(0, 31)), rand_word()));
        if ($urandom_range(0, 15) == 0) begin
          // jump to just below the top of memory so fetch wraps
          send_beat(load_beat(base, insn(OP_BEQ, 3'd0, 3'd0, 16'hFFFC - base)));
          k = 1;
        end else begin
          k = $urandom_range(3, 12);
          for (int i = 0; i < k; i++) send_beat(load_beat(base + 16'(i), rand_insn()));
        end
        repeat (k + $urandom_range(2, 8)) send_beat(tick_beat());
      end
    end

    // fill the pipeline with noops, then halt and poke at the halted unit
    calm    = 1'b1;
    flushed = 1'b0;
    for (int tries = 0; tries < 20 && !flushed; tries++) begin
      drain();
      base = last_pc;
      for (int i = 0; i < 6; i++) send_beat(load_beat(base + 16'(i), NOOP_WORD));
      repeat (6) send_beat(tick_beat());
      drain();
      flushed = (last_pc == base + 16'd6);
    end
    send_beat(load_beat(last_pc, insn(OP_HALT, 3'd0, 3'd0, 16'd0)));
    repeat (8) send_beat(tick_beat());
    send_beat(load_beat(16'($urandom), $urandom));
    repeat (4) send_beat(tick_beat());

    drain();
    repeat (20) @(negedge clk_i);
    $display("Ran %0d memory loads and %0d pipeline ticks of random programs;", n_loads,
             n_ticks);
    $display("halt reached at the end: %0d, mismatches: %0d", last_halt, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding", pending);
    $display("FAILURE");
    $finish;
  end

endmodule

// File: lc2k_five_stage_pipeline_unit.f
+incdir+rtl
rtl/lc2k_pkg.sv
rtl/lc2k_mem.sv
rtl/lc2k_regfile.sv
rtl/lc2k_core.sv
rtl/lc2k_five_stage_pipeline_unit.sv
bench/lc2k_pipeline_checker.sv
bench/tb_top.sv
